// ===== src/gridpoint_correlation_accumulator_defines.svh =====
// Assertion macros shared by the correlation accumulator RTL.
// Compiled out when SYNTHESIS is defined; no other dependencies.
`ifndef GRIDPOINT_CORRELATION_ACCUMULATOR_DEFINES_SVH
`define GRIDPOINT_CORRELATION_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clock edge outside reset
`define GCA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GCA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GCA_ASSERT_IMP(lbl, ante, cons, msg)
`define GCA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/gca_pkg.sv =====
// Shared types, constants and the correlation micro-program.
// Used by every module of the correlation accumulator; no dependencies.
package gca_pkg;

	localparam int IDX_W  = 12;
	localparam int SMP_W  = 24;
	localparam int SUM_W  = 40;
	localparam int SQ_W   = 64;
	localparam int CNT_W  = 17;
	localparam int CORR_W = 16;
	localparam int IN_W   = 64;
	localparam int OUT_W  = 32;

	localparam int LIMB_W = 32;
	localparam int LIMBS  = 8;
	localparam int LIDX_W = 3;
	localparam int BIG_W  = LIMB_W * LIMBS;
	localparam int MOP_W  = 33;
	localparam int PROD_W = 2 * MOP_W;

	localparam int POINTS_DEF      = 4096;
	localparam int MAX_STEPS_DEF   = 65536;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic [3:0]  TOP_BIT = 4'd13;

	// configuration register indexes
	localparam logic CFG_MISS_A = 1'b0;
	localparam logic CFG_MISS_B = 1'b1;

	// micro-op codes
	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_CHK = 2'd2;
	localparam logic [1:0] OP_CMP = 2'd3;

	// big register codes
	localparam logic [3:0] R_N   = 4'd0;
	localparam logic [3:0] R_SA  = 4'd1;
	localparam logic [3:0] R_SB  = 4'd2;
	localparam logic [3:0] R_SAA = 4'd3;
	localparam logic [3:0] R_SBB = 4'd4;
	localparam logic [3:0] R_SAB = 4'd5;
	localparam logic [3:0] R_T   = 4'd6;
	localparam logic [3:0] R_NUM = 4'd7;
	localparam logic [3:0] R_VA  = 4'd8;
	localparam logic [3:0] R_VB  = 4'd9;
	localparam logic [3:0] R_V   = 4'd10;
	localparam logic [3:0] R_L   = 4'd11;
	localparam logic [3:0] R_K   = 4'd12;
	localparam logic [3:0] R_KK  = 4'd13;
	localparam logic [3:0] R_C30 = 4'd14;

	localparam logic [3:0] PC_LOOP = 4'd13;

	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic signed [SUM_W-1:0] sa;
		logic signed [SUM_W-1:0] sb;
		logic signed [SQ_W-1:0]  saa;
		logic signed [SQ_W-1:0]  sbb;
		logic signed [SQ_W-1:0]  sab;
	} entry_t;

	typedef struct packed {
		logic signed [MOP_W-1:0] a;
		logic signed [MOP_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic                     miss;
		logic signed [CORR_W-1:0] corr;
	} corr_res_t;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] d;
	} instr_t;

	// moments, variances, then a bisection on |r| against num^2 * 2^30
	function automatic instr_t prog(input logic [3:0] pc);
		instr_t i;
		unique case (pc)
			4'd0:  i = '{OP_MUL, R_N,   R_SAB, R_T};
			4'd1:  i = '{OP_MUL, R_SA,  R_SB,  R_NUM};
			4'd2:  i = '{OP_SUB, R_T,   R_NUM, R_NUM};
			4'd3:  i = '{OP_MUL, R_N,   R_SAA, R_T};
			4'd4:  i = '{OP_MUL, R_SA,  R_SA,  R_VA};
			4'd5:  i = '{OP_SUB, R_T,   R_VA,  R_VA};
			4'd6:  i = '{OP_MUL, R_N,   R_SBB, R_T};
			4'd7:  i = '{OP_MUL, R_SB,  R_SB,  R_VB};
			4'd8:  i = '{OP_SUB, R_T,   R_VB,  R_VB};
			4'd9:  i = '{OP_CHK, R_VA,  R_VB,  R_T};
			4'd10: i = '{OP_MUL, R_VA,  R_VB,  R_V};
			4'd11: i = '{OP_MUL, R_NUM, R_NUM, R_T};
			4'd12: i = '{OP_MUL, R_T,   R_C30, R_L};
			4'd13: i = '{OP_MUL, R_K,   R_K,   R_KK};
			4'd14: i = '{OP_MUL, R_KK,  R_V,   R_T};
			4'd15: i = '{OP_CMP, R_T,   R_L,   R_T};
			default: i = '{OP_CHK, R_VA, R_VB, R_T};
		endcase
		return i;
	endfunction

endpackage

// ===== src/gca_state_ram.sv =====
// Per-point accumulator store: one write port, one registered read port.
// Depends on gca_pkg for the entry type.
module gca_state_ram import gca_pkg::*; #(
	parameter int DEPTH  = POINTS_DEF,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== src/gca_mult.sv =====
// Shared 33x33 signed multiplier with a registered product.
// Depends on gca_pkg for the request type.
module gca_mult import gca_pkg::*; (
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= $signed(req.a) * $signed(req.b);
	end

	assign prod = prod_q;

endmodule

// ===== src/gca_corr_engine.sv =====
// Correlation sequencer: multi-limb products over the shared multiplier, subtracts,
// and a bit-by-bit search of |r|. Depends on gca_pkg and the assertion macros.
`include "gridpoint_correlation_accumulator_defines.svh"

module gca_corr_engine import gca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  entry_t                   ent,
	output mul_req_t                 mreq,
	input  logic signed [PROD_W-1:0] prod,
	output corr_res_t                res
);

	localparam logic [1:0] E_IDLE = 2'd0;
	localparam logic [1:0] E_EXEC = 2'd1;
	localparam logic [1:0] E_MUL  = 2'd2;

	logic [1:0]        st_q;
	logic [3:0]        pc_q;
	logic [BIG_W-1:0]  rn_q, rsa_q, rsb_q, rsaa_q, rsbb_q, rsab_q;
	logic [BIG_W-1:0]  rt_q, rnum_q, rva_q, rvb_q, rv_q, rl_q, rkk_q;
	logic [BIG_W-1:0]  ma_q, mb_q, r_q;
	logic [LIDX_W-1:0] i_q, j_q, pi_q, pj_q;
	logic              iss_q, p_vld_q;
	logic [LIMB_W-1:0] carry_q;
	logic [14:0]       lo_q;
	logic [3:0]        bit_q;
	logic              first_q;
	corr_res_t         res_q;

	instr_t            instr;
	logic [BIG_W-1:0]  src_a, src_b, r_next, wval, kval;
	logic [14:0]       cand, lo_new;
	logic [15:0]       kodd;
	logic [LIDX_W-1:0] limb;
	logic [63:0]       acc;
	logic              mul_fin, wen, pass, bad, fin_cmp;

	always_comb begin
		instr = prog(pc_q);
		cand  = first_q ? ONE_Q14 : (lo_q | (15'd1 << bit_q));
		kodd  = {cand, 1'b0} - 16'd1;
		kval  = BIG_W'(kodd);
		case (instr.a)
			R_N:     src_a = rn_q;
			R_SA:    src_a = rsa_q;
			R_SB:    src_a = rsb_q;
			R_SAA:   src_a = rsaa_q;
			R_SBB:   src_a = rsbb_q;
			R_SAB:   src_a = rsab_q;
			R_T:     src_a = rt_q;
			R_NUM:   src_a = rnum_q;
			R_VA:    src_a = rva_q;
			R_VB:    src_a = rvb_q;
			R_V:     src_a = rv_q;
			R_L:     src_a = rl_q;
			R_K:     src_a = kval;
			R_KK:    src_a = rkk_q;
			R_C30:   src_a = BIG_W'(64'd1 << 30);
			default: src_a = '0;
		endcase
		case (instr.b)
			R_N:     src_b = rn_q;
			R_SA:    src_b = rsa_q;
			R_SB:    src_b = rsb_q;
			R_SAA:   src_b = rsaa_q;
			R_SBB:   src_b = rsbb_q;
			R_SAB:   src_b = rsab_q;
			R_T:     src_b = rt_q;
			R_NUM:   src_b = rnum_q;
			R_VA:    src_b = rva_q;
			R_VB:    src_b = rvb_q;
			R_V:     src_b = rv_q;
			R_L:     src_b = rl_q;
			R_K:     src_b = kval;
			R_KK:    src_b = rkk_q;
			R_C30:   src_b = BIG_W'(64'd1 << 30);
			default: src_b = '0;
		endcase

		// product limb add: prod + partial + carry of the row
		limb   = pi_q + pj_q;
		acc    = prod[63:0] + 64'(r_q[limb*LIMB_W +: LIMB_W])
			+ ((pj_q == '0) ? 64'd0 : 64'(carry_q));
		r_next = r_q;
		r_next[limb*LIMB_W +: LIMB_W] = acc[LIMB_W-1:0];
		mul_fin = (st_q == E_MUL) && p_vld_q && (pi_q == LIDX_W'(LIMBS - 1));

		wen  = ((st_q == E_EXEC) && (instr.op == OP_SUB)) || mul_fin;
		wval = (st_q == E_MUL) ? r_next : (src_a - src_b);

		bad = (rva_q == '0) || (rvb_q == '0) || rva_q[BIG_W-1] || rvb_q[BIG_W-1];
		pass = !(src_a > src_b);
		lo_new = pass ? cand : lo_q;
		fin_cmp = first_q ? pass : (bit_q == '0);

		mreq.a = {1'b0, ma_q[i_q*LIMB_W +: LIMB_W]};
		mreq.b = {1'b0, mb_q[j_q*LIMB_W +: LIMB_W]};
	end

	// operand and destination registers
	always_ff @(posedge clk) begin
		if (start) begin
			rn_q   <= BIG_W'(ent.cnt);
			rsa_q  <= BIG_W'(ent.sa);
			rsb_q  <= BIG_W'(ent.sb);
			rsaa_q <= BIG_W'(ent.saa);
			rsbb_q <= BIG_W'(ent.sbb);
			rsab_q <= BIG_W'(ent.sab);
		end
		if (wen) begin
			case (instr.d)
				R_T:     rt_q   <= wval;
				R_NUM:   rnum_q <= wval;
				R_VA:    rva_q  <= wval;
				R_VB:    rvb_q  <= wval;
				R_V:     rv_q   <= wval;
				R_L:     rl_q   <= wval;
				R_KK:    rkk_q  <= wval;
				default: rt_q   <= rt_q;
			endcase
		end
		if ((st_q == E_EXEC) && (instr.op == OP_MUL)) begin
			ma_q <= src_a;
			mb_q <= src_b;
			r_q  <= '0;
		end else if (p_vld_q) begin
			r_q     <= r_next;
			carry_q <= acc[63:32];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= E_IDLE;
			pc_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			pi_q    <= '0;
			pj_q    <= '0;
			iss_q   <= 1'b0;
			p_vld_q <= 1'b0;
			lo_q    <= '0;
			bit_q   <= '0;
			first_q <= 1'b1;
			res_q   <= '0;
		end else begin
			// done lasts one cycle; the engine is idle while it is high
			if (res_q.done) begin
				res_q.done <= 1'b0;
			end
			unique case (st_q)
				E_IDLE: begin
					if (start) begin
						st_q    <= E_EXEC;
						pc_q    <= '0;
						lo_q    <= '0;
						first_q <= 1'b1;
					end
				end
				E_EXEC: begin
					unique case (instr.op)
						OP_MUL: begin
							i_q   <= '0;
							j_q   <= '0;
							iss_q <= 1'b1;
							st_q  <= E_MUL;
						end
						OP_SUB: pc_q <= pc_q + 4'd1;
						OP_CHK: begin
							if (bad) begin
								res_q <= '{1'b1, 1'b1, '0};
								st_q  <= E_IDLE;
							end else begin
								pc_q <= pc_q + 4'd1;
							end
						end
						OP_CMP: begin
							lo_q <= lo_new;
							if (fin_cmp) begin
								res_q.done <= 1'b1;
								res_q.miss <= 1'b0;
								res_q.corr <= rnum_q[BIG_W-1] ? -CORR_W'(lo_new)
									: CORR_W'(lo_new);
								st_q       <= E_IDLE;
							end else begin
								pc_q <= PC_LOOP;
								if (first_q) begin
									first_q <= 1'b0;
									bit_q   <= TOP_BIT;
								end else begin
									bit_q <= bit_q - 4'd1;
								end
							end
						end
						default: st_q <= E_IDLE;
					endcase
				end
				E_MUL: begin
					// issue limb products row by row, dropping those above the top limb
					p_vld_q <= iss_q;
					pi_q    <= i_q;
					pj_q    <= j_q;
					if (iss_q) begin
						if (i_q == LIDX_W'(LIMBS - 1)) begin
							iss_q <= 1'b0;
						end else if ((i_q + j_q) == LIDX_W'(LIMBS - 1)) begin
							i_q <= i_q + 1'b1;
							j_q <= '0;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					if (mul_fin) begin
						p_vld_q <= 1'b0;
						pc_q    <= pc_q + 4'd1;
						st_q    <= E_EXEC;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	assign res = res_q;

	`GCA_ASSERT_IMP(a_start_idle, start, st_q == E_IDLE, "engine started while busy")
	`GCA_ASSERT_IMP(a_pvld_mul, p_vld_q, st_q == E_MUL, "product in flight outside multiply")
	`GCA_ASSERT_IMP(a_corr_range, res_q.done && !res_q.miss,
		(res_q.corr <= 16'sd16384) && (res_q.corr >= -16'sd16384),
		"correlation beyond unit magnitude")

endmodule

// ===== src/gridpoint_correlation_accumulator.sv =====
// Per-point Pearson correlation accumulator. Each input beat carries a point index,
// one sample of each of two series and a last-step flag. Unless a sample equals its
// missing code (registers 0 and 1 on the cfg channel), the point's count, sums, sums
// of squares and cross sum are added to a per-point store; once a point holds
// MAX_STEPS pairs, further pairs are dropped. A beat with the last-step flag adds its
// pair first, then emits one result: r in Q2.14 rounded to nearest (ties away from
// zero), saturated to +/-1.0, and clears the point. A zero count or zero variance, or
// an index at or above POINTS, gives missing = 1 with correlation 0. Beats without the
// flag emit nothing. After reset the store is cleared one entry per cycle, and s_tready
// stays low meanwhile; config writes are taken at any time. A normal beat steps through
// accept, then three products (a*a, b*b, a*b) through the one shared 33x33 multiplier,
// and the store write. A last-step beat then runs the correlation sequencer on the same
// multiplier: each wide product is a schoolbook pass of 36 limb products at one per
// cycle, nine of them for the moments and up to thirty for the search of |r| in up to
// fifteen steps. A finished result waits in the output register while the next beat
// is accepted.
`include "gridpoint_correlation_accumulator_defines.svh"

module gridpoint_correlation_accumulator import gca_pkg::*; #(
	parameter int POINTS      = POINTS_DEF,
	parameter int MAX_STEPS   = MAX_STEPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// input beats
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // point_index[11:0], sample_a[35:12], sample_b[59:36]
	input  logic             s_tlast,   // last_step
	// result beats
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // result_index[11:0], correlation[27:12]
	output logic             m_tuser,   // missing
	// configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [SMP_W-1:0] cfg_data
);

	localparam int ADDR_W = (POINTS > 1) ? $clog2(POINTS) : 1;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MA   = 3'd2;
	localparam logic [2:0] S_MB   = 3'd3;
	localparam logic [2:0] S_MC   = 3'd4;
	localparam logic [2:0] S_MD   = 3'd5;
	localparam logic [2:0] S_CORR = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	logic [2:0]               state_q;
	logic [ADDR_W-1:0]        clr_q;
	logic [SMP_W-1:0]         mca_q, mcb_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [SMP_W-1:0]  a_q, b_q;
	logic                     last_q, ok_q, rng_q;
	logic signed [PROD_W-1:0] aa_q, bb_q;
	logic signed [CORR_W-1:0] pend_corr_q, corr_q;
	logic                     pend_miss_q, miss_q, out_vld_q;
	logic [IDX_W-1:0]         ridx_q;

	logic                     accept;
	logic [IDX_W-1:0]         in_idx;
	logic signed [SMP_W-1:0]  in_a, in_b, mca_sx, mcb_sx;
	entry_t                   rd_data, upd, wr_data, eng_ent;
	logic                     wr_en, acc_ok, eng_start;
	logic [ADDR_W-1:0]        wr_addr;
	mul_req_t                 mreq, acc_req, eng_req;
	logic signed [PROD_W-1:0] prod;
	corr_res_t                eng_res;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;

	// samples and missing codes are compared as SAMPLE_BITS-bit values
	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_a   = SMP_W'($signed(s_tdata[IDX_W +: SAMPLE_BITS]));
	assign in_b   = SMP_W'($signed(s_tdata[IDX_W+SMP_W +: SAMPLE_BITS]));
	assign mca_sx = SMP_W'($signed(mca_q[SAMPLE_BITS-1:0]));
	assign mcb_sx = SMP_W'($signed(mcb_q[SAMPLE_BITS-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mca_q <= SMP_W'(24'h800000);
			mcb_q <= SMP_W'(24'h800000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MISS_A: mca_q <= cfg_data;
				CFG_MISS_B: mcb_q <= cfg_data;
				default:    mca_q <= mca_q;
			endcase
		end
	end

	// hold the beat's fields for the read-modify-write
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= in_idx;
			a_q    <= in_a;
			b_q    <= in_b;
			last_q <= s_tlast;
			ok_q   <= (in_a != mca_sx) && (in_b != mcb_sx);
			rng_q  <= (32'(in_idx) < 32'(POINTS));
		end
		if (state_q == S_MB) begin
			aa_q <= prod;
		end
		if (state_q == S_MC) begin
			bb_q <= prod;
		end
	end

	// accumulate: products come back in the cycle after issue
	always_comb begin
		acc_req = '0;
		case (state_q)
			S_MA:    acc_req = '{MOP_W'(a_q), MOP_W'(a_q)};
			S_MB:    acc_req = '{MOP_W'(b_q), MOP_W'(b_q)};
			S_MC:    acc_req = '{MOP_W'(a_q), MOP_W'(b_q)};
			default: acc_req = '0;
		endcase
		mreq = (state_q == S_CORR) ? eng_req : acc_req;

		acc_ok  = ok_q && rng_q && (rd_data.cnt < CNT_W'(MAX_STEPS));
		upd.cnt = rd_data.cnt + 1'b1;
		upd.sa  = rd_data.sa + SUM_W'(a_q);
		upd.sb  = rd_data.sb + SUM_W'(b_q);
		upd.saa = rd_data.saa + SQ_W'(aa_q);
		upd.sbb = rd_data.sbb + SQ_W'(bb_q);
		upd.sab = rd_data.sab + SQ_W'(prod);
		eng_ent = acc_ok ? upd : rd_data;

		// clear the point on its last step
		wr_en     = (state_q == S_CLR) || ((state_q == S_MD) && rng_q && (last_q || acc_ok));
		wr_addr   = (state_q == S_CLR) ? clr_q : ADDR_W'(idx_q);
		wr_data   = ((state_q == S_CLR) || last_q) ? '0 : upd;
		eng_start = (state_q == S_MD) && last_q && rng_q;
	end

	gca_state_ram #(
		.DEPTH  (POINTS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (ADDR_W'(in_idx)),
		.rd_data (rd_data)
	);

	gca_mult u_mult (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	gca_corr_engine u_eng (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.ent    (eng_ent),
		.mreq   (eng_req),
		.prod   (prod),
		.res    (eng_res)
	);

	// main control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_vld_q   <= 1'b0;
			pend_miss_q <= 1'b0;
			pend_corr_q <= '0;
		end else begin
			// a result leaving while the next one is loaded is handled in S_EMIT
			if (out_vld_q && m_tready && (state_q != S_EMIT)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(POINTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MA;
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: state_q <= S_MC;
				S_MC: state_q <= S_MD;
				S_MD: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (rng_q) begin
						state_q <= S_CORR;
					end else begin
						pend_miss_q <= 1'b1;
						pend_corr_q <= '0;
						state_q     <= S_EMIT;
					end
				end
				S_CORR: begin
					if (eng_res.done) begin
						pend_miss_q <= eng_res.miss;
						pend_corr_q <= eng_res.corr;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					// wait for the output register to drain
					if (!out_vld_q || m_tready) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && (!out_vld_q || m_tready)) begin
			ridx_q <= idx_q;
			corr_q <= pend_corr_q;
			miss_q <= pend_miss_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(OUT_W - IDX_W - CORR_W)'(0), corr_q, ridx_q};
	assign m_tuser  = miss_q;

	`GCA_ASSERT_NXT(a_accept_seq, s_tvalid && s_tready, state_q == S_MA,
		"accepted beat did not start accumulation")
	`GCA_ASSERT_IMP(a_eng_done, eng_res.done, state_q == S_CORR,
		"correlation result outside correlation phase")
	`GCA_ASSERT_IMP(a_wr_state, wr_en, (state_q == S_CLR) || (state_q == S_MD),
		"store written outside clear or update")

endmodule
